// ===== sv/quadratic_root_solver_top_assert.svh =====
// Assertion macros used by the solver top. They expect clk and arst_n in scope.
`ifndef QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QRS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/qrs_pkg.sv =====
package qrs_pkg;

	localparam int DW     = 32;
	localparam int FRAC   = 16;
	localparam int PROD_W = 2 * DW;
	localparam int DISC_W = 2 * DW + 3;
	localparam int RAD_W  = 2 * DW + 2;
	localparam int ROOT_W = RAD_W / 2;
	localparam int SREM_W = ROOT_W + 2;
	localparam int NB_W   = DW + 1;
	localparam int NUMS_W = DW + 3;
	localparam int NUMM_W = DW + 2;
	localparam int NUM_W  = NUMM_W + FRAC;
	localparam int DEN_W  = DW + 1;
	localparam int CMP_W  = (DEN_W + DW > NUM_W) ? DEN_W + DW : NUM_W;

	typedef logic [DW-1:0]            mag_t;
	typedef logic [PROD_W-1:0]        prod_t;
	typedef logic signed [DISC_W-1:0] disc_t;
	typedef logic [RAD_W-1:0]         rad_t;
	typedef logic [ROOT_W-1:0]        sroot_t;
	typedef logic [SREM_W-1:0]        srem_t;
	typedef logic signed [NB_W-1:0]   nb_t;
	typedef logic signed [NUMS_W-1:0] nums_t;
	typedef logic [NUMM_W-1:0]        numm_t;
	typedef logic [NUM_W-1:0]         num_t;
	typedef logic [DEN_W-1:0]         den_t;
	typedef logic [CMP_W-1:0]         cmp_t;

	typedef enum logic [2:0] {
		CLS_NONE    = 3'd0,
		CLS_ONE     = 3'd1,
		CLS_TWO     = 3'd2,
		CLS_ALL     = 3'd3,
		CLS_COMPLEX = 3'd4
	} root_class_t;

	typedef struct packed {
		root_class_t cls;
		num_t        n1;
		logic        n1_neg;
		num_t        n2;
		logic        n2_neg;
		den_t        den;
		logic        den_neg;
	} div_in_t;

	typedef struct packed {
		root_class_t cls;
		mag_t        r1;
		logic        sat1;
		mag_t        r2;
		logic        sat2;
	} div_out_t;

endpackage

// ===== sv/qrs_if.sv =====
interface qrs_coef_if;
	logic                        valid;
	logic                        ready;
	logic signed [qrs_pkg::DW-1:0] coef_a;
	logic signed [qrs_pkg::DW-1:0] coef_b;
	logic signed [qrs_pkg::DW-1:0] coef_c;

	modport source (output valid, coef_a, coef_b, coef_c, input ready);
	modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_root_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    root_class;
	logic signed [qrs_pkg::DW-1:0] root_one;
	logic signed [qrs_pkg::DW-1:0] root_two;
	logic                          saturated;

	modport source (output valid, root_class, root_one, root_two, saturated, input ready);
	modport sink (input valid, root_class, root_one, root_two, saturated, output ready);
endinterface

// ===== sv/quadratic_root_solver_top.sv =====
// Channel | Dir | Payload
// coef    | in  | coef_a, coef_b, coef_c (signed fixed point)
// root    | out | root_class, root_one, root_two, saturated
//
// One coefficient set can be taken every cycle while no result waits on root; the depth is
// four front stages, DW+1 square-root stages, DW+2 divider stages and the output register.
// The square-root chain (one root bit per stage) and the divider (one quotient bit per
// stage) set the depth. arst_n clears only the valid bits. While a result waits on root,
// the whole pipeline holds and coef is not ready; nothing is dropped or repeated.
`include "quadratic_root_solver_top_assert.svh"

module quadratic_root_solver_top (
	input  logic       clk,
	input  logic       arst_n,
	qrs_coef_if.sink   coef,
	qrs_root_if.source root
);

	typedef struct packed {
		qrs_pkg::root_class_t cls;
		qrs_pkg::nb_t         nb;
		qrs_pkg::mag_t        c_mag;
		logic                 c_nneg;
		qrs_pkg::den_t        den;
		logic                 den_neg;
		logic                 lin;
	} side_t;

	typedef struct packed {
		side_t            side;
		qrs_pkg::rad_t    rad;
		qrs_pkg::srem_t   rem;
		qrs_pkg::sroot_t  res;
	} sq_t;

	logic adv;

	qrs_pkg::mag_t a_in, b_in, c_in;

	logic          v_s1, v_s2, v_s3;
	qrs_pkg::mag_t a_mag_s1, b_mag_s1, c_mag_s1;
	logic          a_neg_s1, b_neg_s1, c_neg_s1;
	logic          a_zero_s1, b_zero_s1, c_zero_s1;

	qrs_pkg::prod_t bb_s2, ac_s2;
	logic           acn_s2;
	qrs_pkg::mag_t  a_mag_s2, b_mag_s2, c_mag_s2;
	logic           a_neg_s2, b_neg_s2, c_neg_s2;
	logic           a_zero_s2, b_zero_s2, c_zero_s2;

	qrs_pkg::disc_t bb_x, fac_x;
	qrs_pkg::disc_t disc_s3;
	qrs_pkg::mag_t  a_mag_s3, b_mag_s3, c_mag_s3;
	logic           a_neg_s3, b_neg_s3, c_neg_s3;
	logic           a_zero_s3, b_zero_s3, c_zero_s3;

	sq_t  sq_in;
	sq_t  sq_s  [0:qrs_pkg::ROOT_W];
	logic sqv_s [0:qrs_pkg::ROOT_W];

	sq_t              sq_last;
	qrs_pkg::nums_t   nbx, rx, n1, n2;
	qrs_pkg::numm_t   m1, m2;
	logic             neg1;
	qrs_pkg::div_in_t din;

	logic              div_valid;
	qrs_pkg::div_out_t dout;
	logic              has1, has2;

	logic                 v_so;
	qrs_pkg::root_class_t cls_so;
	qrs_pkg::mag_t        r1_so, r2_so;
	logic                 sat_so;

	// The pipeline advances as one unless a finished result is not taken.
	assign adv = !v_so || root.ready;
	assign coef.ready = adv;

	assign a_in = coef.coef_a;
	assign b_in = coef.coef_b;
	assign c_in = coef.coef_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			sqv_s[0] <= 1'b0;
		end else if (adv) begin
			v_s1 <= coef.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			sqv_s[0] <= v_s3;
		end
	end

	// Stage 1: sign and magnitude of each coefficient.
	always_ff @(posedge clk) begin
		if (adv) begin
			a_neg_s1 <= a_in[qrs_pkg::DW-1];
			b_neg_s1 <= b_in[qrs_pkg::DW-1];
			c_neg_s1 <= c_in[qrs_pkg::DW-1];
			a_mag_s1 <= a_in[qrs_pkg::DW-1] ? (~a_in + 1'b1) : a_in;
			b_mag_s1 <= b_in[qrs_pkg::DW-1] ? (~b_in + 1'b1) : b_in;
			c_mag_s1 <= c_in[qrs_pkg::DW-1] ? (~c_in + 1'b1) : c_in;
			a_zero_s1 <= (a_in == '0);
			b_zero_s1 <= (b_in == '0);
			c_zero_s1 <= (c_in == '0);
		end
	end

	// Stage 2: the two products of the discriminant.
	always_ff @(posedge clk) begin
		if (adv) begin
			bb_s2 <= qrs_pkg::prod_t'(b_mag_s1) * qrs_pkg::prod_t'(b_mag_s1);
			ac_s2 <= qrs_pkg::prod_t'(a_mag_s1) * qrs_pkg::prod_t'(c_mag_s1);
			acn_s2 <= a_neg_s1 ^ c_neg_s1;
			a_mag_s2 <= a_mag_s1;
			b_mag_s2 <= b_mag_s1;
			c_mag_s2 <= c_mag_s1;
			a_neg_s2 <= a_neg_s1;
			b_neg_s2 <= b_neg_s1;
			c_neg_s2 <= c_neg_s1;
			a_zero_s2 <= a_zero_s1;
			b_zero_s2 <= b_zero_s1;
			c_zero_s2 <= c_zero_s1;
		end
	end

	// Stage 3: d = b*b - 4*a*c, exact.
	always_comb begin
		bb_x = qrs_pkg::disc_t'(bb_s2);
		fac_x = qrs_pkg::disc_t'({ac_s2, 2'b00});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			disc_s3 <= acn_s2 ? (bb_x + fac_x) : (bb_x - fac_x);
			a_mag_s3 <= a_mag_s2;
			b_mag_s3 <= b_mag_s2;
			c_mag_s3 <= c_mag_s2;
			a_neg_s3 <= a_neg_s2;
			b_neg_s3 <= b_neg_s2;
			c_neg_s3 <= c_neg_s2;
			a_zero_s3 <= a_zero_s2;
			b_zero_s3 <= b_zero_s2;
			c_zero_s3 <= c_zero_s2;
		end
	end

	// Stage 4: class, radicand and divider operands.
	always_comb begin
		sq_in = '0;
		if (!a_zero_s3) begin
			if (disc_s3 < 0) begin
				sq_in.side.cls = qrs_pkg::CLS_COMPLEX;
			end else if (disc_s3 == 0) begin
				sq_in.side.cls = qrs_pkg::CLS_ONE;
			end else begin
				sq_in.side.cls = qrs_pkg::CLS_TWO;
				sq_in.rad = disc_s3[qrs_pkg::RAD_W-1:0];
			end
		end else if (!b_zero_s3) begin
			sq_in.side.cls = qrs_pkg::CLS_ONE;
		end else if (c_zero_s3) begin
			sq_in.side.cls = qrs_pkg::CLS_ALL;
		end else begin
			sq_in.side.cls = qrs_pkg::CLS_NONE;
		end
		sq_in.side.nb = b_neg_s3 ? qrs_pkg::nb_t'(b_mag_s3) : -qrs_pkg::nb_t'(b_mag_s3);
		sq_in.side.c_mag = c_mag_s3;
		sq_in.side.c_nneg = !c_neg_s3 && !c_zero_s3;
		sq_in.side.den = a_zero_s3 ? qrs_pkg::den_t'(b_mag_s3) : {a_mag_s3, 1'b0};
		sq_in.side.den_neg = a_zero_s3 ? b_neg_s3 : a_neg_s3;
		sq_in.side.lin = a_zero_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s[0] <= sq_in;
		end
	end

	// Floor square root, one root bit per stage: bring down two radicand bits and
	// subtract 4*root+1 when it fits.
	for (genvar k = 0; k < qrs_pkg::ROOT_W; k++) begin : g_sq
		logic [qrs_pkg::SREM_W+1:0] cur;
		logic [qrs_pkg::SREM_W+1:0] trial;
		logic                       ge;
		sq_t                        nxt;

		always_comb begin
			cur = {sq_s[k].rem, sq_s[k].rad[qrs_pkg::RAD_W-1 -: 2]};
			trial = {{(qrs_pkg::SREM_W-qrs_pkg::ROOT_W){1'b0}}, sq_s[k].res, 2'b01};
			ge = (cur >= trial);
			nxt = sq_s[k];
			nxt.rad = sq_s[k].rad << 2;
			nxt.rem = ge ? qrs_pkg::srem_t'(cur - trial) : qrs_pkg::srem_t'(cur);
			nxt.res = {sq_s[k].res[qrs_pkg::ROOT_W-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqv_s[k+1] <= 1'b0;
			end else if (adv) begin
				sqv_s[k+1] <= sqv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[k+1] <= nxt;
			end
		end
	end

	// Numerators -b + r and -b - r, or -c in the linear case, scaled by 2^FRAC.
	always_comb begin
		sq_last = sq_s[qrs_pkg::ROOT_W];
		nbx = qrs_pkg::nums_t'(sq_last.side.nb);
		rx = qrs_pkg::nums_t'(sq_last.res);
		n1 = nbx + rx;
		n2 = nbx - rx;
		m1 = (n1 < 0) ? qrs_pkg::numm_t'(-n1) : qrs_pkg::numm_t'(n1);
		m2 = (n2 < 0) ? qrs_pkg::numm_t'(-n2) : qrs_pkg::numm_t'(n2);
		neg1 = (n1 < 0);
		if (sq_last.side.lin) begin
			m1 = qrs_pkg::numm_t'(sq_last.side.c_mag);
			neg1 = sq_last.side.c_nneg;
		end
		din.cls = sq_last.side.cls;
		din.n1 = qrs_pkg::num_t'(m1) << qrs_pkg::FRAC;
		din.n1_neg = neg1;
		din.n2 = qrs_pkg::num_t'(m2) << qrs_pkg::FRAC;
		din.n2_neg = (n2 < 0);
		din.den = sq_last.side.den;
		din.den_neg = sq_last.side.den_neg;
	end

	qrs_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (sqv_s[qrs_pkg::ROOT_W]),
		.din       (din),
		.out_valid (div_valid),
		.dout      (dout)
	);

	// Output register: roots the class does not give read as zero.
	assign has1 = (dout.cls == qrs_pkg::CLS_ONE) || (dout.cls == qrs_pkg::CLS_TWO);
	assign has2 = (dout.cls == qrs_pkg::CLS_TWO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_so <= 1'b0;
		end else if (adv) begin
			v_so <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_so <= dout.cls;
			r1_so <= has1 ? dout.r1 : '0;
			r2_so <= has2 ? dout.r2 : '0;
			sat_so <= (has1 && dout.sat1) || (has2 && dout.sat2);
		end
	end

	assign root.valid = v_so;
	assign root.root_class = cls_so;
	assign root.root_one = r1_so;
	assign root.root_two = r2_so;
	assign root.saturated = sat_so;

	`QRS_ASSERT_NOW(a_two_only, root.valid && (root.root_class != qrs_pkg::CLS_TWO), root.root_two == '0, "second root set without two roots")
	`QRS_ASSERT_NOW(a_no_root, root.valid && (root.root_class != qrs_pkg::CLS_ONE) && (root.root_class != qrs_pkg::CLS_TWO), (root.root_one == '0) && !root.saturated, "root or saturation set without a root")
	`QRS_ASSERT_NOW(a_stall_ready, root.valid && !root.ready, !coef.ready, "input ready while the output is stalled")
	`QRS_ASSERT_NEXT(a_stall_hold, root.valid && !root.ready, $stable(v_s1) && $stable(sqv_s[0]) && $stable(div_valid), "pipeline moved during a stall")

endmodule

// ===== sv/qrs_div_pipe.sv =====
// Two restoring dividers sharing one denominator, one quotient bit per stage.
// A numerator of at least den * 2^DW is flagged up front and saturates.
module qrs_div_pipe (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  qrs_pkg::div_in_t  din,
	output logic              out_valid,
	output qrs_pkg::div_out_t dout
);

	typedef struct packed {
		qrs_pkg::root_class_t cls;
		logic                 n1_neg;
		logic                 n2_neg;
		qrs_pkg::den_t        den;
		logic                 den_neg;
		qrs_pkg::num_t        rem1;
		qrs_pkg::num_t        rem2;
		qrs_pkg::mag_t        q1;
		qrs_pkg::mag_t        q2;
		logic                 ovf1;
		logic                 ovf2;
	} dstage_t;

	typedef struct packed {
		qrs_pkg::mag_t r;
		logic          sat;
	} fin_t;

	qrs_pkg::div_in_t in_s1;
	logic             in_v_s1;
	dstage_t          dv_s [0:qrs_pkg::DW];
	logic             dvv_s [0:qrs_pkg::DW];
	qrs_pkg::cmp_t    den_top;
	fin_t             f1;
	fin_t             f2;

	function automatic fin_t finish(input qrs_pkg::mag_t q, input logic ovf, input logic sneg);
		fin_t          f;
		logic          neg;
		qrs_pkg::mag_t lim;
		qrs_pkg::mag_t qq;
		neg = sneg && (ovf || (q != '0));
		lim = neg ? {1'b1, {(qrs_pkg::DW-1){1'b0}}} : {1'b0, {(qrs_pkg::DW-1){1'b1}}};
		f.sat = ovf || (q > lim);
		qq = f.sat ? lim : q;
		f.r = neg ? (~qq + 1'b1) : qq;
		return f;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
			dvv_s[0] <= 1'b0;
		end else if (adv) begin
			in_v_s1 <= in_valid;
			dvv_s[0] <= in_v_s1;
		end
	end

	assign den_top = qrs_pkg::cmp_t'(in_s1.den) << qrs_pkg::DW;

	always_ff @(posedge clk) begin
		if (adv) begin
			in_s1 <= din;
			dv_s[0].cls <= in_s1.cls;
			dv_s[0].n1_neg <= in_s1.n1_neg;
			dv_s[0].n2_neg <= in_s1.n2_neg;
			dv_s[0].den <= in_s1.den;
			dv_s[0].den_neg <= in_s1.den_neg;
			dv_s[0].rem1 <= in_s1.n1;
			dv_s[0].rem2 <= in_s1.n2;
			dv_s[0].q1 <= '0;
			dv_s[0].q2 <= '0;
			dv_s[0].ovf1 <= qrs_pkg::cmp_t'(in_s1.n1) >= den_top;
			dv_s[0].ovf2 <= qrs_pkg::cmp_t'(in_s1.n2) >= den_top;
		end
	end

	for (genvar j = 0; j < qrs_pkg::DW; j++) begin : g_div
		localparam int BIT = qrs_pkg::DW - 1 - j;
		qrs_pkg::cmp_t dsub;
		logic          ge1;
		logic          ge2;
		dstage_t       nxt;

		always_comb begin
			dsub = qrs_pkg::cmp_t'(dv_s[j].den) << BIT;
			ge1 = !dv_s[j].ovf1 && (qrs_pkg::cmp_t'(dv_s[j].rem1) >= dsub);
			ge2 = !dv_s[j].ovf2 && (qrs_pkg::cmp_t'(dv_s[j].rem2) >= dsub);
			nxt = dv_s[j];
			if (ge1) begin
				nxt.rem1 = qrs_pkg::num_t'(qrs_pkg::cmp_t'(dv_s[j].rem1) - dsub);
				nxt.q1[BIT] = 1'b1;
			end
			if (ge2) begin
				nxt.rem2 = qrs_pkg::num_t'(qrs_pkg::cmp_t'(dv_s[j].rem2) - dsub);
				nxt.q2[BIT] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvv_s[j+1] <= 1'b0;
			end else if (adv) begin
				dvv_s[j+1] <= dvv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[j+1] <= nxt;
			end
		end
	end

	always_comb begin
		f1 = finish(dv_s[qrs_pkg::DW].q1, dv_s[qrs_pkg::DW].ovf1,
			dv_s[qrs_pkg::DW].n1_neg ^ dv_s[qrs_pkg::DW].den_neg);
		f2 = finish(dv_s[qrs_pkg::DW].q2, dv_s[qrs_pkg::DW].ovf2,
			dv_s[qrs_pkg::DW].n2_neg ^ dv_s[qrs_pkg::DW].den_neg);
		dout.cls = dv_s[qrs_pkg::DW].cls;
		dout.r1 = f1.r;
		dout.sat1 = f1.sat;
		dout.r2 = f2.r;
		dout.sat2 = f2.sat;
	end

	assign out_valid = dvv_s[qrs_pkg::DW];

endmodule
